/* rtl/rsp_pkg.sv */
// Shared types, register indexes, status codes and constants of the proximity test.
package rsp_pkg;

  // fraction bits of every coordinate, default
  localparam int FRAC_BITS_DEF = 16;

  // latency of one pipelined wide multiplier
  localparam int MUL_LAT = 6;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_HIT_RADIUS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PARALLEL_LIMIT = 2'd1;

  localparam logic [30:0] HIT_RADIUS_RST     = 31'd32768;
  localparam logic [30:0] PARALLEL_LIMIT_RST = 31'd1;

  // result status codes
  localparam logic [2:0] ST_HIT       = 3'd0;
  localparam logic [2:0] ST_PARALLEL  = 3'd1;
  localparam logic [2:0] ST_OUTSIDE   = 3'd2;
  localparam logic [2:0] ST_MISS      = 3'd3;
  localparam logic [2:0] ST_ZERO_AXIS = 3'd4;

  localparam logic [31:0] PARAM_SAT = 32'h7FFF_FFFF;

  typedef struct packed {
    logic signed [31:0] ray_origin_x;
    logic signed [31:0] ray_origin_y;
    logic signed [31:0] ray_origin_z;
    logic signed [31:0] ray_dir_x;
    logic signed [31:0] ray_dir_y;
    logic signed [31:0] ray_dir_z;
    logic signed [31:0] seg_start_x;
    logic signed [31:0] seg_start_y;
    logic signed [31:0] seg_start_z;
    logic signed [31:0] seg_end_x;
    logic signed [31:0] seg_end_y;
    logic signed [31:0] seg_end_z;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] ray_param;
    logic [2:0]         status;
  } out_item_t;

endpackage

/* rtl/rsp_dly.sv */
// Enabled shift-register delay line of fixed depth.
module rsp_dly #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr_r [N];

  // advance the line while the pipe moves
  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= d;
      for (int i = 1; i < N; i++) begin
        sr_r[i] <= sr_r[i-1];
      end
    end
  end

  assign q = sr_r[N-1];

endmodule

/* rtl/rsp_mul.sv */
// Pipelined signed multiplier built from 32x32 partial products, six stages.
module rsp_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [AW-1:0]     a,
  input  logic signed [BW-1:0]     b,
  output logic signed [AW+BW-1:0]  p
);

  // limb counts; the row adder tree takes up to four rows of a
  localparam int LA = (AW + 31) / 32;
  localparam int LB = (BW + 31) / 32;
  localparam int RW = 32 * (LB + 1);
  localparam int PW = 32 * (LA + LB);

  logic [AW-1:0]     abs_a;
  logic [BW-1:0]     abs_b;
  logic [32*LA-1:0]  ma_r;
  logic [32*LB-1:0]  mb_r;
  logic [4:0]        sg_r;
  logic [63:0]       pp_r [LA][LB];
  logic [RW-1:0]     ev [LA];
  logic [RW-1:0]     od [LA];
  logic [RW-1:0]     row_r [LA];
  logic [PW-1:0]     rx [4];
  logic [PW-1:0]     s0_r, s1_r, t_r;
  logic signed [AW+BW-1:0] p_r;

  // take magnitudes and the product sign
  assign abs_a = a[AW-1] ? (~a + 1'b1) : a;
  assign abs_b = b[BW-1] ? (~b + 1'b1) : b;

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r  <= (32*LA)'(abs_a);
      mb_r  <= (32*LB)'(abs_b);
      sg_r  <= {sg_r[3:0], a[AW-1] ^ b[BW-1]};
    end
  end

  // form all limb products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LA; i++) begin
        for (int j = 0; j < LB; j++) begin
          pp_r[i][j] <= ma_r[32*i +: 32] * mb_r[32*j +: 32];
        end
      end
    end
  end

  // even and odd limb products do not overlap: one add per row
  always_comb begin
    for (int i = 0; i < LA; i++) begin
      ev[i] = '0;
      od[i] = '0;
      for (int j = 0; j < LB; j++) begin
        if (j % 2 == 0) begin
          ev[i][32*j +: 64] = pp_r[i][j];
        end else begin
          od[i][32*j +: 64] = pp_r[i][j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LA; i++) begin
        row_r[i] <= ev[i] + od[i];
      end
    end
  end

  // align rows; missing rows read as zero
  for (genvar g = 0; g < 4; g++) begin : g_rx
    if (g < LA) begin : g_on
      assign rx[g] = PW'(row_r[g]) << (32 * g);
    end else begin : g_off
      assign rx[g] = '0;
    end
  end

  // two-level row sum, then apply the sign
  always_ff @(posedge clk) begin
    if (en) begin
      s0_r <= rx[0] + rx[1];
      s1_r <= rx[2] + rx[3];
      t_r  <= s0_r + s1_r;
      p_r  <= $signed((AW+BW)'(sg_r[4] ? (~t_r + 1'b1) : t_r));
    end
  end

  assign p = p_r;

endmodule

/* rtl/ray_segment_proximity_test.sv */
// Top level: ray versus axis-segment closest approach test, fully pipelined.
//
// Usage:
//   in_valid/in_stall/in_data carry one request: ray origin and direction and
//   the axis segment start and end, signed fixed point with FRAC_BITS
//   fraction bits. out_valid/out_stall/out_data return one result per
//   request: hit, the saturated ray parameter (0 unless hit) and a status.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write hit_radius (index 0) and
//   parallel_limit (index 1); cfg_ready is always high. Write them only while
//   no request is in flight.
// Throughput: one request per cycle while the pipeline is not held by a stall.
// Pipeline: an input stage, three rounds of six-stage multipliers, the first two
//   each followed by a sum stage and the third by a decision stage, 32 stages of
//   restoring division for the ray parameter and an output register.
// Stall: while out_valid is high and out_stall is high the whole pipeline
//   holds, in_stall rises and nothing is lost or repeated.
// Reset: synchronous active-low rst_n empties the pipeline and loads the
//   register defaults (radius 0.5, parallel limit one LSB).
module ray_segment_proximity_test #(
  parameter int FRAC_BITS = rsp_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  rsp_pkg::in_item_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output rsp_pkg::out_item_t                   out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rsp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [31:0]                          cfg_data
);

  import rsp_pkg::*;

  localparam int BV   = 68;                 // first-round sums
  localparam int CV   = 140;                // second-round sums
  localparam int WNW  = 103;                // w.n
  localparam int DIVW = CV + 32;            // divider remainder
  localparam int LAT  = 2 + 3 * (MUL_LAT + 1) + 32;

  logic en;
  logic [LAT-1:0] vld_r;
  logic [30:0] hit_radius_r, parallel_limit_r;

  // the pipe moves unless a finished result is held
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;
  assign out_valid = vld_r[LAT-1];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_radius_r     <= HIT_RADIUS_RST;
      parallel_limit_r <= PARALLEL_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HIT_RADIUS:     hit_radius_r     <= cfg_data[30:0];
        REG_PARALLEL_LIMIT: parallel_limit_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // ---------------- input stage: u = E - S, w = O - S ----------------
  logic signed [31:0] in_o [3], in_d [3], in_s [3], in_e [3];
  logic signed [32:0] u_r [3], w_r [3];
  logic signed [31:0] d_r [3];

  assign in_o = '{in_data.ray_origin_x, in_data.ray_origin_y, in_data.ray_origin_z};
  assign in_d = '{in_data.ray_dir_x, in_data.ray_dir_y, in_data.ray_dir_z};
  assign in_s = '{in_data.seg_start_x, in_data.seg_start_y, in_data.seg_start_z};
  assign in_e = '{in_data.seg_end_x, in_data.seg_end_y, in_data.seg_end_z};

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        u_r[i] <= 33'(in_e[i]) - 33'(in_s[i]);
        w_r[i] <= 33'(in_o[i]) - 33'(in_s[i]);
        d_r[i] <= in_d[i];
      end
    end
  end

  // ---------------- first multiply round ----------------
  logic signed [65:0] p_uu [3], p_wu [3];
  logic signed [63:0] p_aa [3];
  logic signed [64:0] p_bu [3], p_dw [3], p_cx1 [3], p_cx2 [3];

  for (genvar g = 0; g < 3; g++) begin : g_r1
    localparam int J = (g + 1) % 3;
    localparam int K = (g + 2) % 3;
    rsp_mul #(.AW(33), .BW(33)) u_uu (.clk, .en, .a(u_r[g]), .b(u_r[g]), .p(p_uu[g]));
    rsp_mul #(.AW(33), .BW(33)) u_wu (.clk, .en, .a(w_r[g]), .b(u_r[g]), .p(p_wu[g]));
    rsp_mul #(.AW(32), .BW(32)) u_aa (.clk, .en, .a(d_r[g]), .b(d_r[g]), .p(p_aa[g]));
    rsp_mul #(.AW(32), .BW(33)) u_bu (.clk, .en, .a(d_r[g]), .b(u_r[g]), .p(p_bu[g]));
    rsp_mul #(.AW(32), .BW(33)) u_dw (.clk, .en, .a(d_r[g]), .b(w_r[g]), .p(p_dw[g]));
    rsp_mul #(.AW(32), .BW(33)) u_c1 (.clk, .en, .a(d_r[J]), .b(u_r[K]), .p(p_cx1[g]));
    rsp_mul #(.AW(32), .BW(33)) u_c2 (.clk, .en, .a(d_r[K]), .b(u_r[J]), .p(p_cx2[g]));
  end

  // hold w until the second round
  logic [98:0] w_dly;
  logic signed [32:0] wd [3];

  rsp_dly #(.W(99), .N(MUL_LAT + 1)) u_wdly (
    .clk, .en, .d({w_r[2], w_r[1], w_r[0]}), .q(w_dly)
  );

  for (genvar g = 0; g < 3; g++) begin : g_wd
    assign wd[g] = $signed(w_dly[33*g +: 33]);
  end

  // ---------------- first sum stage ----------------
  logic signed [BV-1:0] uu_r, a_r, bu_r, wu_r, dw_r;
  logic signed [BV-1:0] n_r [3];
  logic signed [BV-1:0] uu_nxt;
  logic                 uz_r;

  assign uu_nxt = BV'(p_uu[0]) + BV'(p_uu[1]) + BV'(p_uu[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      uu_r <= uu_nxt;
      uz_r <= (uu_nxt == 0);
      a_r  <= BV'(p_aa[0]) + BV'(p_aa[1]) + BV'(p_aa[2]);
      bu_r <= BV'(p_bu[0]) + BV'(p_bu[1]) + BV'(p_bu[2]);
      wu_r <= BV'(p_wu[0]) + BV'(p_wu[1]) + BV'(p_wu[2]);
      dw_r <= BV'(p_dw[0]) + BV'(p_dw[1]) + BV'(p_dw[2]);
      for (int i = 0; i < 3; i++) begin
        n_r[i] <= BV'(p_cx1[i]) - BV'(p_cx2[i]);
      end
    end
  end

  // ---------------- second multiply round ----------------
  logic signed [2*BV-1:0] p_nn [3];
  logic signed [BV+32:0]  p_wn [3];
  logic signed [BV+31:0]  p_lu;
  logic signed [2*BV-1:0] p_awu, p_bdw, p_bwu, p_dwu;

  for (genvar g = 0; g < 3; g++) begin : g_r2
    rsp_mul #(.AW(BV), .BW(BV)) u_nn (.clk, .en, .a(n_r[g]), .b(n_r[g]), .p(p_nn[g]));
    rsp_mul #(.AW(33), .BW(BV)) u_wn (.clk, .en, .a(wd[g]), .b(n_r[g]), .p(p_wn[g]));
  end

  rsp_mul #(.AW(32), .BW(BV)) u_lu (
    .clk, .en, .a($signed({1'b0, parallel_limit_r})), .b(uu_r), .p(p_lu)
  );
  rsp_mul #(.AW(BV), .BW(BV)) u_awu (.clk, .en, .a(a_r),  .b(wu_r), .p(p_awu));
  rsp_mul #(.AW(BV), .BW(BV)) u_bdw (.clk, .en, .a(bu_r), .b(dw_r), .p(p_bdw));
  rsp_mul #(.AW(BV), .BW(BV)) u_bwu (.clk, .en, .a(bu_r), .b(wu_r), .p(p_bwu));
  rsp_mul #(.AW(BV), .BW(BV)) u_dwu (.clk, .en, .a(dw_r), .b(uu_r), .p(p_dwu));

  logic uz_d;
  rsp_dly #(.W(1), .N(MUL_LAT)) u_uzdly (.clk, .en, .d(uz_r), .q(uz_d));

  // radius squared follows the register; it is settled long before use
  logic signed [63:0] p_rr;
  rsp_mul #(.AW(32), .BW(32)) u_rr (
    .clk, .en(1'b1),
    .a($signed({1'b0, hit_radius_r})), .b($signed({1'b0, hit_radius_r})), .p(p_rr)
  );

  // ---------------- second sum stage ----------------
  logic signed [CV-1:0]  nn_r, rhs_r, tn_r, sn_r;
  logic signed [WNW-1:0] wn_r;
  logic                  uz_c_r;

  always_ff @(posedge clk) begin
    if (en) begin
      nn_r   <= CV'(p_nn[0]) + CV'(p_nn[1]) + CV'(p_nn[2]);
      rhs_r  <= CV'(p_lu) <<< FRAC_BITS;
      tn_r   <= CV'(p_awu) - CV'(p_bdw);
      sn_r   <= CV'(p_bwu) - CV'(p_dwu);
      wn_r   <= WNW'(p_wn[0]) + WNW'(p_wn[1]) + WNW'(p_wn[2]);
      uz_c_r <= uz_d;
    end
  end

  // early decisions, held while the gap products form
  logic f_par, f_out, f_snle;
  logic [3:0] flg_d;
  logic [2*CV-1:0] sn_nn_d;

  assign f_par  = (nn_r == 0) || (nn_r < rhs_r);
  assign f_out  = (tn_r < 0) || (tn_r > nn_r);
  assign f_snle = (sn_r <= 0);

  rsp_dly #(.W(4), .N(MUL_LAT)) u_flgdly (
    .clk, .en, .d({uz_c_r, f_par, f_out, f_snle}), .q(flg_d)
  );
  rsp_dly #(.W(2*CV), .N(MUL_LAT)) u_sndly (
    .clk, .en, .d({sn_r, nn_r}), .q(sn_nn_d)
  );

  // ---------------- third multiply round ----------------
  logic signed [2*WNW-1:0] p_lhs;
  logic signed [CV+63:0]   p_rhs;

  rsp_mul #(.AW(WNW), .BW(WNW)) u_lhs (.clk, .en, .a(wn_r), .b(wn_r), .p(p_lhs));
  rsp_mul #(.AW(64), .BW(CV))   u_rhs (.clk, .en, .a(p_rr), .b(nn_r), .p(p_rhs));

  // ---------------- decision stage ----------------
  logic [2:0]    st_nxt, st_d_r;
  logic [CV-1:0] sn_d_r, nn_d_r;
  logic          far;

  assign far = p_lhs > (2*WNW)'(p_rhs);

  always_comb begin
    if (flg_d[3]) begin
      st_nxt = ST_ZERO_AXIS;
    end else if (flg_d[2]) begin
      st_nxt = ST_PARALLEL;
    end else if (flg_d[1]) begin
      st_nxt = ST_OUTSIDE;
    end else if (far || flg_d[0]) begin
      st_nxt = ST_MISS;
    end else begin
      st_nxt = ST_HIT;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_d_r <= st_nxt;
      sn_d_r <= sn_nn_d[2*CV-1:CV];
      nn_d_r <= sn_nn_d[CV-1:0];
    end
  end

  // ---------------- ray parameter division, one bit a stage ----------------
  logic [DIVW-1:0] dv_rem_r [32];
  logic [CV-1:0]   dv_nn_r  [32];
  logic [30:0]     dv_q_r   [32];
  logic [2:0]      dv_st_r  [32];
  logic            dv_sat_r [32];
  logic [DIVW-1:0] rem0;

  assign rem0 = DIVW'(sn_d_r) << FRAC_BITS;

  // saturate when the quotient reaches 2^31
  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem_r[0] <= rem0;
      dv_nn_r[0]  <= nn_d_r;
      dv_q_r[0]   <= '0;
      dv_st_r[0]  <= st_d_r;
      dv_sat_r[0] <= rem0 >= (DIVW'(nn_d_r) << 31);
    end
  end

  for (genvar k = 1; k < 32; k++) begin : g_div
    localparam int B = 31 - k;
    logic [DIVW-1:0] sub;
    logic            ge;

    assign sub = DIVW'(dv_nn_r[k-1]) << B;
    assign ge  = dv_rem_r[k-1] >= sub;

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem_r[k] <= ge ? (dv_rem_r[k-1] - sub) : dv_rem_r[k-1];
        dv_nn_r[k]  <= dv_nn_r[k-1];
        dv_q_r[k]   <= dv_q_r[k-1] | (31'(ge) << B);
        dv_st_r[k]  <= dv_st_r[k-1];
        dv_sat_r[k] <= dv_sat_r[k-1];
      end
    end
  end

  // ---------------- output register ----------------
  out_item_t out_r, out_nxt;

  always_comb begin
    out_nxt.hit       = (dv_st_r[31] == ST_HIT);
    out_nxt.status    = dv_st_r[31];
    out_nxt.ray_param = '0;
    if (out_nxt.hit) begin
      out_nxt.ray_param = dv_sat_r[31] ? $signed(PARAM_SAT) : $signed({1'b0, dv_q_r[31]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

  // ---------------- checks ----------------
  a_hit_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.hit == (out_data.status == ST_HIT)))
    else $error("hit flag disagrees with status");

  a_miss_param: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.hit) |-> (out_data.ray_param == 0))
    else $error("ray parameter nonzero on a miss");

  a_param_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.ray_param[31] && out_data.status <= ST_ZERO_AXIS))
    else $error("ray parameter negative or status out of range");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result presented right after reset");

endmodule

/* tb/tb_ray_segment_proximity_test.sv */
// Testbench for the ray versus axis-segment proximity test: random and directed requests.
module tb_ray_segment_proximity_test;
  import rsp_pkg::*;

  typedef logic signed [255:0] wide_t;

  // Scoreboard: predicts each accepted request and checks results in order
  class proximity_scoreboard;
    out_item_t   pending_q[$];
    logic [30:0] radius;
    logic [30:0] par_limit;
    int          errors;
    int          status_seen[5];

    function new();
      radius    = HIT_RADIUS_RST;
      par_limit = PARALLEL_LIMIT_RST;
      errors    = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function wide_t dot3(wide_t a[3], wide_t b[3]);
      return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    endfunction

    // Compute the closest-approach decision with exact wide integers
    function out_item_t predict(in_item_t x);
      wide_t     o[3], d[3], u[3], w[3], n[3];
      wide_t     uu, nn, a, bu, wu, dw, tn, sn, wn, rr, quot;
      out_item_t r;
      o[0] = wide_t'(x.ray_origin_x); o[1] = wide_t'(x.ray_origin_y);
      o[2] = wide_t'(x.ray_origin_z);
      d[0] = wide_t'(x.ray_dir_x); d[1] = wide_t'(x.ray_dir_y); d[2] = wide_t'(x.ray_dir_z);
      u[0] = wide_t'(x.seg_end_x) - wide_t'(x.seg_start_x);
      u[1] = wide_t'(x.seg_end_y) - wide_t'(x.seg_start_y);
      u[2] = wide_t'(x.seg_end_z) - wide_t'(x.seg_start_z);
      w[0] = o[0] - wide_t'(x.seg_start_x);
      w[1] = o[1] - wide_t'(x.seg_start_y);
      w[2] = o[2] - wide_t'(x.seg_start_z);
      r.hit = 1'b0;
      r.ray_param = '0;
      uu = dot3(u, u);
      if (uu == 0) begin
        r.status = ST_ZERO_AXIS;
        return r;
      end
      n[0] = d[1] * u[2] - d[2] * u[1];
      n[1] = d[2] * u[0] - d[0] * u[2];
      n[2] = d[0] * u[1] - d[1] * u[0];
      nn = dot3(n, n);
      if (nn == 0 || nn < ((wide_t'(par_limit) * uu) <<< FRAC_BITS_DEF)) begin
        r.status = ST_PARALLEL;
        return r;
      end
      a  = dot3(d, d);
      bu = dot3(d, u);
      wu = dot3(w, u);
      dw = dot3(d, w);
      tn = a * wu - bu * dw;
      if (tn < 0 || tn > nn) begin
        r.status = ST_OUTSIDE;
        return r;
      end
      wn = dot3(w, n);
      rr = wide_t'(radius);
      sn = bu * wu - dw * uu;
      if (wn * wn > rr * rr * nn || sn <= 0) begin
        r.status = ST_MISS;
        return r;
      end
      quot = (sn <<< FRAC_BITS_DEF) / nn;
      r.status    = ST_HIT;
      r.hit       = 1'b1;
      r.ray_param = (quot >= (wide_t'(1) <<< 31)) ? PARAM_SAT : quot[31:0];
      return r;
    endfunction

    function void note_request(in_item_t x);
      pending_q.push_back(predict(x));
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (pending_q.size() == 0) begin
        $error("result with no request pending: %p", got);
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (exp_r.status <= ST_ZERO_AXIS) status_seen[exp_r.status]++;
      if (got.hit !== exp_r.hit) begin
        $error("hit: expected %0d, got %0d", exp_r.hit, got.hit);
        errors++;
      end
      if (got.ray_param !== exp_r.ray_param) begin
        $error("ray_param: expected %0h, got %0h", exp_r.ray_param, got.ray_param);
        errors++;
      end
      if (got.status !== exp_r.status) begin
        $error("status: expected %0d, got %0d", exp_r.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  proximity_scoreboard sb;
  int                  idle_cycles;
  int                  stall_mode;
  int                  stall_left;
  int                  requests_sent;

  ray_segment_proximity_test u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Receiver stall: switch now and then at random among four stall patterns
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_mode <= 0;
      stall_left <= 0;
    end else begin
      if ($urandom_range(63) == 0) stall_mode <= $urandom_range(3);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(1) == 0);
        2: begin
          if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
          end else if ($urandom_range(15) == 0) begin
            stall_left <= $urandom_range(15);
            out_stall  <= 1'b1;
          end else begin
            out_stall <= 1'b0;
          end
        end
        default: out_stall <= ($urandom_range(7) == 0);
      endcase
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 3000) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Drive one request and hold it until accepted
  task automatic send_request(in_item_t x);
    in_valid <= 1'b1;
    in_data  <= x;
    do @(posedge clk); while (in_stall);
    sb.note_request(x);
    requests_sent++;
    // random gap between bursts
    if ($urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_HIT_RADIUS) sb.radius = val[30:0];
    else if (idx == REG_PARALLEL_LIMIT) sb.par_limit = val[30:0];
    @(posedge clk);
  endtask

  // Drain the pipeline before touching the registers
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [31:0] near_coord();
    return $signed($urandom_range(32'h000A_0000)) - 32'sh0005_0000;
  endfunction

  function automatic in_item_t full_random();
    in_item_t x;
    x = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return x;
  endfunction

  // Build a ray aimed near a point on the segment, with random spread
  function automatic in_item_t aimed_request();
    in_item_t           x;
    logic signed [31:0] px, py, pz, k;
    int                 frac;
    x.seg_start_x = near_coord(); x.seg_start_y = near_coord(); x.seg_start_z = near_coord();
    x.seg_end_x = x.seg_start_x + near_coord();
    x.seg_end_y = x.seg_start_y + near_coord();
    x.seg_end_z = x.seg_start_z + near_coord();
    frac = $urandom_range(12) - 1;
    px = x.seg_start_x + ((x.seg_end_x - x.seg_start_x) / 10) * frac;
    py = x.seg_start_y + ((x.seg_end_y - x.seg_start_y) / 10) * frac;
    pz = x.seg_start_z + ((x.seg_end_z - x.seg_start_z) / 10) * frac;
    x.ray_dir_x = near_coord() >>> $urandom_range(4);
    x.ray_dir_y = near_coord() >>> $urandom_range(4);
    x.ray_dir_z = near_coord() >>> $urandom_range(4);
    k = $urandom_range(4) - 1;
    x.ray_origin_x = px - x.ray_dir_x * k + ($signed($urandom_range(32'h2_0000)) - 32'sh1_0000);
    x.ray_origin_y = py - x.ray_dir_y * k + ($signed($urandom_range(32'h2_0000)) - 32'sh1_0000);
    x.ray_origin_z = pz - x.ray_dir_z * k + ($signed($urandom_range(32'h2_0000)) - 32'sh1_0000);
    // sometimes make the ray parallel to the axis, or collapse the axis
    case ($urandom_range(19))
      0: begin
        x.ray_dir_x = x.seg_end_x - x.seg_start_x;
        x.ray_dir_y = x.seg_end_y - x.seg_start_y;
        x.ray_dir_z = x.seg_end_z - x.seg_start_z;
      end
      1: begin
        x.seg_end_x = x.seg_start_x; x.seg_end_y = x.seg_start_y; x.seg_end_z = x.seg_start_z;
      end
      default: ;
    endcase
    return x;
  endfunction

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3) == 0) send_request(full_random());
      else send_request(aimed_request());
    end
  endtask

  initial begin
    in_item_t x;
    sb            = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    requests_sent = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, zero axis, parallel, behind, hit, saturation
    send_request('0);
    x = '1;
    send_request(x);
    x = {12{32'h8000_0000}};
    send_request(x);
    x = {12{32'h7FFF_FFFF}};
    send_request(x);
    x = '0; x.seg_end_x = 32'h7FFF_FFFF; x.seg_start_x = 32'h8000_0000;
    x.ray_dir_y = 32'h8000_0000; x.ray_origin_y = 32'h7FFF_FFFF;
    send_request(x);
    // hit: ray down the y axis crosses the x axis segment at x = 1
    x = '0; x.seg_end_x = 32'h0002_0000; x.ray_origin_x = 32'h0001_0000;
    x.ray_origin_y = 32'h0003_0000; x.ray_dir_y = 32'hFFFF_0000;
    send_request(x);
    // same ray pointing away: behind
    x.ray_dir_y = 32'h0001_0000;
    send_request(x);
    // tiny direction: huge parameter saturates
    x.ray_dir_y = 32'hFFFF_FFFF; x.ray_origin_y = 32'h7FFF_0000;
    send_request(x);
    // crossing beyond the segment end
    x = '0; x.seg_end_x = 32'h0002_0000; x.ray_origin_x = 32'h0005_0000;
    x.ray_origin_y = 32'h0003_0000; x.ray_dir_y = 32'hFFFF_0000;
    send_request(x);
    // gap just over the radius
    x.ray_origin_x = 32'h0001_0000; x.ray_origin_z = 32'h0000_8001;
    send_request(x);
    x.ray_origin_z = 32'h0000_8000;
    send_request(x);
    // parallel to the axis
    x = '0; x.seg_end_z = 32'h0001_0000; x.ray_dir_z = 32'h0004_0000;
    x.ray_origin_x = 32'h0000_1000;
    send_request(x);
    for (int i = 0; i < 8; i++) send_request(aimed_request());

    // Random phases across register settings
    for (int phase = 0; phase < 6; phase++) begin
      drain();
      case (phase)
        0: begin write_reg(REG_HIT_RADIUS, 32'h0002_0000); write_reg(REG_PARALLEL_LIMIT, 0); end
        1: begin write_reg(REG_HIT_RADIUS, 32'hFFFF_FFFF); write_reg(REG_PARALLEL_LIMIT, 1); end
        2: begin write_reg(REG_HIT_RADIUS, 0); write_reg(REG_PARALLEL_LIMIT, 32'h7FFF_FFFF); end
        3: begin
          write_reg(REG_HIT_RADIUS, $urandom);
          write_reg(REG_PARALLEL_LIMIT, $urandom_range(32'h0001_0000));
        end
        4: begin write_reg(REG_HIT_RADIUS, 32'h8001_0000); write_reg(REG_PARALLEL_LIMIT, 32'h8000_0000); end
        default: begin
          write_reg(REG_HIT_RADIUS, $urandom_range(32'h0004_0000));
          write_reg(REG_PARALLEL_LIMIT, $urandom_range(255));
        end
      endcase
      run_random(65);
    end

    drain();
    $display("requests: %0d; hit %0d, parallel %0d, outside %0d, miss %0d, zero axis %0d",
             requests_sent, sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
             sb.status_seen[3], sb.status_seen[4]);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/rsp_pkg.sv
rtl/rsp_dly.sv
rtl/rsp_mul.sv
rtl/ray_segment_proximity_test.sv
tb/tb_ray_segment_proximity_test.sv
